// ----- design/gdd_pkg.sv -----
// ----------------------------------------------------------------------------
// gdd_pkg
// shared constants, tables and control types of the date difference block
// ----------------------------------------------------------------------------
package gdd_pkg;

  localparam int YEAR_W   = 14;
  localparam int MONTH_W  = 4;
  localparam int DAY_W    = 5;
  localparam int DAYS_W   = 23;
  localparam int WDAY_W   = 3;
  localparam int DOY_W    = 9;
  localparam int MLEN_W   = 5;
  localparam int YLEN_W   = 9;
  localparam int IN_W     = 48;
  localparam int OUT_W    = 56;

  localparam logic [YEAR_W-1:0]  BASE_YEAR = 14'd1601;
  localparam logic [YEAR_W-1:0]  MAX_YEAR  = 14'd9999;
  localparam logic [MONTH_W-1:0] MONTH_MIN = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_MAX = 4'd12;

  // residues of the base year, used to seed the leap counters
  localparam logic [1:0] BASE_MOD4   = 2'd1;
  localparam logic [6:0] BASE_MOD100 = 7'd1;
  localparam logic [8:0] BASE_MOD400 = 9'd1;

  typedef struct packed {
    logic load;
    logic step;
    logic out_load;
  } gdd_cmd_t;

  typedef struct packed {
    logic last;
  } gdd_sts_t;

  function automatic logic [YEAR_W-1:0] clamp_year(input logic [YEAR_W-1:0] y);
    logic [YEAR_W-1:0] r;
    if (y < BASE_YEAR) r = BASE_YEAR;
    else if (y > MAX_YEAR) r = MAX_YEAR;
    else r = y;
    return r;
  endfunction

  function automatic logic [MONTH_W-1:0] clamp_month(input logic [MONTH_W-1:0] m);
    logic [MONTH_W-1:0] r;
    if (m < MONTH_MIN) r = MONTH_MIN;
    else if (m > MONTH_MAX) r = MONTH_MAX;
    else r = m;
    return r;
  endfunction

  // days before the first of the month, month 1..12
  function automatic logic [DOY_W-1:0] month_offset(input logic leap,
                                                    input logic [MONTH_W-1:0] m);
    logic [DOY_W-1:0] r;
    case (m)
      4'd1:    r = 9'd0;
      4'd2:    r = 9'd31;
      4'd3:    r = 9'd59;
      4'd4:    r = 9'd90;
      4'd5:    r = 9'd120;
      4'd6:    r = 9'd151;
      4'd7:    r = 9'd181;
      4'd8:    r = 9'd212;
      4'd9:    r = 9'd243;
      4'd10:   r = 9'd273;
      4'd11:   r = 9'd304;
      default: r = 9'd334;
    endcase
    if (leap && (m > 4'd2)) r = r + 9'd1;
    return r;
  endfunction

  function automatic logic [MLEN_W-1:0] month_length(input logic leap,
                                                     input logic [MONTH_W-1:0] m);
    logic [MLEN_W-1:0] r;
    case (m)
      4'd2:    r = leap ? 5'd29 : 5'd28;
      4'd4:    r = 5'd30;
      4'd6:    r = 5'd30;
      4'd9:    r = 5'd30;
      4'd11:   r = 5'd30;
      default: r = 5'd31;
    endcase
    return r;
  endfunction

endpackage

// ----- design/gdd_ctrl.sv -----
// ----------------------------------------------------------------------------
// gdd_ctrl
// sequencer: takes a request, walks the year loop, hands the result to the
// output register
// ----------------------------------------------------------------------------
module gdd_ctrl
  import gdd_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  output logic     in_tready,
  output logic     out_tvalid,
  input  logic     out_tready,
  output gdd_cmd_t cmd,
  input  gdd_sts_t sts
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN  = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic       ovalid_r, ovalid_nxt;
  logic       out_free;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = ovalid_r;
  assign out_free   = !ovalid_r || out_tready;

  always_comb begin
    state_nxt    = state_r;
    cmd.load     = 1'b0;
    cmd.step     = 1'b0;
    cmd.out_load = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_RUN;
        end
      end
      S_RUN: begin
        cmd.step = 1'b1;
        if (sts.last) state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    ovalid_nxt = ovalid_r;
    if (cmd.out_load) ovalid_nxt = 1'b1;
    else if (out_tready) ovalid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> (state_r == S_IDLE))
    else $error("load outside idle");

  a_load_run: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> (state_r == S_RUN))
    else $error("accepted request did not start the year walk");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!ovalid_r || out_tready))
    else $error("result overwrites one not yet taken");

  a_single_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load, cmd.step, cmd.out_load}))
    else $error("more than one datapath command");

endmodule

// ----- design/gdd_datapath.sv -----
// ----------------------------------------------------------------------------
// gdd_datapath
// year walk with running leap residues, day sums and the output register
// ----------------------------------------------------------------------------
module gdd_datapath
  import gdd_pkg::*;
(
  input  logic             clk,
  input  logic [IN_W-1:0]  in_tdata,
  input  gdd_cmd_t         cmd,
  output gdd_sts_t         sts,
  output logic [OUT_W-1:0] out_tdata
);

  logic [YEAR_W-1:0]  fy_r, ty_r, end_r, y_r;
  logic [MONTH_W-1:0] fm_r, tm_r;
  logic [DAY_W-1:0]   fd_r, td_r;
  logic [1:0]         m4_r;
  logic [6:0]         m100_r;
  logic [8:0]         m400_r;
  logic [DAYS_W-1:0]  span_r;
  logic [2:0]         b7_r;
  logic               lf_r, lt_r;
  logic [OUT_W-1:0]   out_r;

  logic [YEAR_W-1:0]  in_fy, in_ty;
  logic               leap_y;
  logic [YLEN_W-1:0]  len_y;
  logic [3:0]         b7_inc;
  logic [2:0]         b7_sum;

  logic [DOY_W-1:0]   from_doy, to_doy;
  logic [DAYS_W-1:0]  between;
  logic [9:0]         wsum;
  logic [14:0]        wprod;
  logic [5:0]         wq;
  logic [3:0]         wrem;
  logic [WDAY_W-1:0]  wday;
  logic [MLEN_W-1:0]  mlen;
  logic [YLEN_W-1:0]  ylen;

  assign in_fy = clamp_year(in_tdata[13:0]);
  assign in_ty = clamp_year(in_tdata[36:23]);

  assign leap_y = ((m4_r == 2'd0) && (m100_r != 7'd0)) || (m400_r == 9'd0);
  assign len_y  = leap_y ? 9'd366 : 9'd365;
  assign b7_inc = {1'b0, b7_r} + (leap_y ? 4'd2 : 4'd1);
  assign b7_sum = (b7_inc >= 4'd7) ? 3'(b7_inc - 4'd7) : 3'(b7_inc);

  assign sts.last = (y_r == end_r);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      fy_r   <= in_fy;
      fm_r   <= clamp_month(in_tdata[17:14]);
      fd_r   <= in_tdata[22:18];
      ty_r   <= in_ty;
      tm_r   <= clamp_month(in_tdata[40:37]);
      td_r   <= in_tdata[45:41];
      end_r  <= (in_fy > in_ty) ? in_fy : in_ty;
      y_r    <= BASE_YEAR;
      m4_r   <= BASE_MOD4;
      m100_r <= BASE_MOD100;
      m400_r <= BASE_MOD400;
      span_r <= '0;
      b7_r   <= '0;
    end else if (cmd.step) begin
      if (y_r == fy_r) lf_r <= leap_y;
      if (y_r == ty_r) lt_r <= leap_y;
      if (y_r < ty_r) begin
        b7_r <= b7_sum;
        if (y_r >= fy_r) span_r <= span_r + DAYS_W'(len_y);
      end
      y_r    <= y_r + 14'd1;
      m4_r   <= m4_r + 2'd1;
      m100_r <= (m100_r == 7'd99) ? 7'd0 : m100_r + 7'd1;
      m400_r <= (m400_r == 9'd399) ? 9'd0 : m400_r + 9'd1;
    end
  end

  assign from_doy = month_offset(lf_r, fm_r) + DOY_W'(fd_r);
  assign to_doy   = month_offset(lt_r, tm_r) + DOY_W'(td_r);
  assign between  = span_r - DAYS_W'(from_doy) + DAYS_W'(to_doy);

  // (b7 + doy - 1) mod 7, shifted by 7 to stay positive; 73/512 reciprocal
  assign wsum  = 10'(b7_r) + 10'(to_doy) + 10'd6;
  assign wprod = 15'(wsum) * 15'd73;
  assign wq    = wprod[14:9];
  assign wrem  = 4'(wsum - 10'(wq) * 10'd7);
  assign wday  = (wrem >= 4'd7) ? 3'(wrem - 4'd7) : 3'(wrem);

  assign mlen = month_length(lt_r, tm_r);
  assign ylen = lt_r ? 9'd366 : 9'd365;

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_r <= {6'd0, ylen, lt_r, mlen, to_doy, wday, between};
    end
  end

  assign out_tdata = out_r;

endmodule

// ----- design/gregorian_date_difference_weekday.sv -----
// ----------------------------------------------------------------------------
// gregorian_date_difference_weekday
// day count between two Gregorian dates, plus weekday and calendar facts of
// the end date
// ----------------------------------------------------------------------------
// One request at a time. After a request is taken the datapath walks the
// years from 1601 up to the later of the two (clamped) years, one year per
// clock, then loads the output register and goes back to idle, where the
// next request can be taken. The result sits in an output register, so the
// next request is taken while the previous result waits to be read; a
// finished result waits until that register is free.
// Years are clamped to 1601..9999 and months to 1..12; days are used as given.
// ----------------------------------------------------------------------------
module gregorian_date_difference_weekday
  import gdd_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  // from_year, from_month, from_day, to_year, to_month, to_day, zero pad
  input  logic [IN_W-1:0]  in_tdata,
  output logic             out_tvalid,
  input  logic             out_tready,
  // days_between, weekday, to_day_of_year, to_month_length, to_leap,
  // to_year_length, zero pad
  output logic [OUT_W-1:0] out_tdata
);

  gdd_cmd_t cmd;
  gdd_sts_t sts;

  gdd_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .sts        (sts)
  );

  gdd_datapath u_datapath (
    .clk       (clk),
    .in_tdata  (in_tdata),
    .cmd       (cmd),
    .sts       (sts),
    .out_tdata (out_tdata)
  );

endmodule

// ----- test/date_result_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// date_result_checker
// watches both streams of the date difference block, works out the day
// count, weekday and calendar facts of every accepted request and compares
// each result the block returns against the oldest outstanding prediction
// ----------------------------------------------------------------------------
module date_result_checker
  import gdd_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  input  logic             in_tready,
  input  logic [IN_W-1:0]  in_tdata,
  input  logic             out_tvalid,
  input  logic             out_tready,
  input  logic [OUT_W-1:0] out_tdata,
  output int               fail_count,
  output int               facts_waiting
);

  localparam int FM_LO = YEAR_W;
  localparam int FD_LO = FM_LO + MONTH_W;
  localparam int TY_LO = FD_LO + DAY_W;
  localparam int TM_LO = TY_LO + YEAR_W;
  localparam int TD_LO = TM_LO + MONTH_W;

  localparam int WD_LO = DAYS_W;
  localparam int DOY_LO = WD_LO + WDAY_W;
  localparam int ML_LO = DOY_LO + DOY_W;
  localparam int LP_LO = ML_LO + MLEN_W;
  localparam int YL_LO = LP_LO + 1;

  typedef struct packed {
    logic [DAYS_W-1:0] days_between;
    logic [WDAY_W-1:0] weekday;
    logic [DOY_W-1:0]  to_day_of_year;
    logic [MLEN_W-1:0] to_month_length;
    logic              to_leap;
    logic [YLEN_W-1:0] to_year_length;
  } date_facts_t;

  date_facts_t facts_due[$];

  initial begin
    fail_count = 0;
    facts_waiting = 0;
  end

  function automatic int leap_of(input int y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic int fit_year(input int y);
    if (y < int'(BASE_YEAR)) return int'(BASE_YEAR);
    if (y > int'(MAX_YEAR)) return int'(MAX_YEAR);
    return y;
  endfunction

  function automatic int fit_month(input int m);
    if (m < 1) return 1;
    if (m > 12) return 12;
    return m;
  endfunction

  function automatic int days_in_month(input int m, input int leap);
    if (m == 2) return 28 + leap;
    if (m == 4 || m == 6 || m == 9 || m == 11) return 30;
    return 31;
  endfunction

  function automatic int ordinal_day(input int y, input int m, input int d);
    int acc;
    acc = d;
    for (int k = 1; k < m; k++) acc += days_in_month(k, leap_of(y));
    return acc;
  endfunction

  function automatic date_facts_t calc_date_facts(input logic [IN_W-1:0] req);
    date_facts_t f;
    int fy, fm, fd, ty, tm, td;
    int span_from, span_base, to_doy, between, wd;
    fy = fit_year(int'(req[0 +: YEAR_W]));
    fm = fit_month(int'(req[FM_LO +: MONTH_W]));
    fd = int'(req[FD_LO +: DAY_W]);
    ty = fit_year(int'(req[TY_LO +: YEAR_W]));
    tm = fit_month(int'(req[TM_LO +: MONTH_W]));
    td = int'(req[TD_LO +: DAY_W]);
    span_from = 0;
    span_base = 0;
    for (int y = int'(BASE_YEAR); y < ty; y++) begin
      span_base += 365 + leap_of(y);
      if (y >= fy) span_from += 365 + leap_of(y);
    end
    to_doy = ordinal_day(ty, tm, td);
    between = span_from - ordinal_day(fy, fm, fd) + to_doy;
    // floor modulo so that the day before the base date lands on sunday
    wd = (span_base + to_doy - 1) % 7;
    if (wd < 0) wd += 7;
    f.days_between = DAYS_W'(between);
    f.weekday = WDAY_W'(wd);
    f.to_day_of_year = DOY_W'(to_doy);
    f.to_month_length = MLEN_W'(days_in_month(tm, leap_of(ty)));
    f.to_leap = leap_of(ty) != 0;
    f.to_year_length = YLEN_W'(365 + leap_of(ty));
    return f;
  endfunction

  always @(posedge clk) begin
    date_facts_t got, want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got.days_between = out_tdata[0 +: DAYS_W];
        got.weekday = out_tdata[WD_LO +: WDAY_W];
        got.to_day_of_year = out_tdata[DOY_LO +: DOY_W];
        got.to_month_length = out_tdata[ML_LO +: MLEN_W];
        got.to_leap = out_tdata[LP_LO];
        got.to_year_length = out_tdata[YL_LO +: YLEN_W];
        if (facts_due.size() == 0) begin
          $display("%0t: unexpected result, expected none, got days %0d wday %0d doy %0d",
                   $time, $signed(got.days_between), got.weekday, got.to_day_of_year);
          fail_count <= fail_count + 1;
        end else begin
          want = facts_due.pop_front();
          if (got != want) begin
            $display("%0t: mismatch, expected days %0d wday %0d doy %0d mlen %0d leap %0d ylen %0d",
                     $time, $signed(want.days_between), want.weekday, want.to_day_of_year,
                     want.to_month_length, want.to_leap, want.to_year_length);
            $display("%0t:           actual days %0d wday %0d doy %0d mlen %0d leap %0d ylen %0d",
                     $time, $signed(got.days_between), got.weekday, got.to_day_of_year,
                     got.to_month_length, got.to_leap, got.to_year_length);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (in_tvalid && in_tready) facts_due.push_back(calc_date_facts(in_tdata));
      facts_waiting <= facts_due.size();
    end
  end

endmodule

// ----- test/gregorian_date_difference_weekday_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gregorian_date_difference_weekday_test
// drives date pair requests into the block with random gaps on both streams,
// a long output stall and a full drain, and reports the checker's verdict
// ----------------------------------------------------------------------------
module gregorian_date_difference_weekday_test;
  import gdd_pkg::*;

  localparam int QUIET_LIMIT = 40000;
  localparam int TAIL_CYCLES = 9000;
  localparam int HOLD_CYCLES = 400;

  typedef enum int {DATES_NEAR, DATES_EARLY, DATES_RAW, DATES_FULL} date_mix_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_tvalid = 1'b0;
  logic             in_tready;
  logic [IN_W-1:0]  in_tdata = '0;
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;

  int fail_count;
  int facts_waiting;
  int quiet_cycles = 0;
  int hold_left = 0;
  int gap_left = 0;
  bit tx_idle = 1'b0;
  bit rx_idle = 1'b0;
  bit rx_hold_req = 1'b0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  gregorian_date_difference_weekday dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  date_result_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .fail_count    (fail_count),
    .facts_waiting (facts_waiting)
  );

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // result side: long hold on request, otherwise random stall bursts
  always @(negedge clk) begin
    if (rx_hold_req) begin
      rx_hold_req = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (gap_left > 0) begin
      gap_left--;
      out_tready <= 1'b0;
    end else if (rx_idle && $urandom_range(0, 5) == 0) begin
      gap_left = $urandom_range(0, 4);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  function automatic logic [IN_W-1:0] pack_dates(input int fy, input int fm, input int fd,
                                                 input int ty, input int tm, input int td);
    return {2'b00, DAY_W'(td), MONTH_W'(tm), YEAR_W'(ty),
            DAY_W'(fd), MONTH_W'(fm), YEAR_W'(fy)};
  endfunction

  function automatic logic [IN_W-1:0] random_dates(input date_mix_t mix);
    case (mix)
      DATES_NEAR:
        return pack_dates(1601 + $urandom_range(0, 450), $urandom_range(1, 12),
                          $urandom_range(1, 31), 1601 + $urandom_range(0, 450),
                          $urandom_range(1, 12), $urandom_range(1, 31));
      DATES_EARLY:
        return pack_dates(1601 + $urandom_range(0, 15), $urandom_range(1, 12),
                          $urandom_range(1, 31), 1601 + $urandom_range(0, 15),
                          $urandom_range(1, 12), $urandom_range(1, 31));
      DATES_RAW:
        return pack_dates($urandom_range(0, 2100), $urandom_range(0, 15),
                          $urandom_range(0, 31), $urandom_range(0, 2100),
                          $urandom_range(0, 15), $urandom_range(0, 31));
      default:
        return pack_dates($urandom_range(0, 16383), $urandom_range(0, 15),
                          $urandom_range(0, 31), $urandom_range(0, 16383),
                          $urandom_range(0, 15), $urandom_range(0, 31));
    endcase
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic offer(input logic [IN_W-1:0] req);
    int gap;
    if (tx_idle && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 5);
      in_tvalid <= 1'b0;
      in_tdata <= {IN_W{1'b1}};
      repeat (gap) @(negedge clk);
    end
    in_tdata <= req;
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (facts_waiting != 0) @(negedge clk);
  endtask

  task automatic send_random(input int count);
    int pick;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 85) offer(random_dates(DATES_NEAR));
      else if (pick < 97) offer(random_dates(DATES_RAW));
      else offer(random_dates(DATES_FULL));
    end
  endtask

  initial begin
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    offer(pack_dates(1601, 1, 1, 1601, 1, 1));
    offer(pack_dates(1601, 1, 1, 1601, 1, 0));
    offer(pack_dates(2000, 6, 15, 1999, 3, 1));
    offer(pack_dates(1600, 1, 1, 1600, 12, 31));
    offer(pack_dates(0, 0, 0, 0, 0, 0));
    offer(pack_dates(16383, 15, 31, 16383, 15, 31));
    offer(pack_dates(9999, 12, 31, 9999, 12, 31));
    offer(pack_dates(10000, 1, 1, 2000, 13, 1));
    offer(pack_dates(1601, 12, 31, 2000, 2, 29));
    offer(pack_dates(1900, 2, 28, 1900, 2, 31));
    offer(pack_dates(2000, 2, 29, 2400, 2, 29));
    offer(pack_dates(2004, 3, 1, 2001, 2, 28));
    offer(pack_dates(1700, 4, 30, 1800, 6, 30));
    offer(pack_dates(1999, 9, 9, 2023, 11, 30));
    offer(pack_dates(1650, 5, 0, 1651, 7, 17));
    offer(pack_dates(1777, 8, 31, 1776, 10, 5));
    offer(pack_dates(1601, 1, 31, 1601, 12, 31));
    offer(pack_dates(1602, 2, 15, 1604, 2, 15));
    drain();

    tx_idle = 1'b1;
    rx_idle = 1'b1;
    send_random(250);

    // stall the result side long enough for the block to back up
    drain();
    @(posedge clk);
    rx_hold_req = 1'b1;
    @(negedge clk);
    for (int i = 0; i < 12; i++) offer(random_dates(DATES_EARLY));

    send_random(250);

    tx_idle = 1'b0;
    rx_idle = 1'b0;
    send_random(60);

    drain();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (fail_count == 0 && facts_waiting == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
